@@ design/small_integer_set_store_macros.svh @@
// Assertion macros for the set store top-level design file.
`ifndef SMALL_INTEGER_SET_STORE_MACROS_SVH
`define SMALL_INTEGER_SET_STORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define SIS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define SIS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SIS_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SIS_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ design/sis_pkg.sv @@
`timescale 1ns / 1ps
package sis_pkg;

  // Request kinds
  localparam logic [1:0] REQ_INSERT   = 2'd0;
  localparam logic [1:0] REQ_REMOVE   = 2'd1;
  localparam logic [1:0] REQ_CONTAINS = 2'd2;
  localparam logic [1:0] REQ_READ     = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_ABSENT  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_BADIDX  = 3'd4;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 4;

  // Per-request controls broadcast to every cell
  typedef struct packed {
    logic ins;  // accepted insert request
    logic rem;  // accepted remove request
  } cell_ctl_t;

endpackage

@@ design/sis_cell.sv @@
`timescale 1ns / 1ps
module sis_cell (
  input  logic                                clk,
  input  sis_pkg::cell_ctl_t                  ctl,
  input  logic                                live,     // slot below the count
  input  logic                                tail,     // slot equals the count
  input  logic signed [sis_pkg::VALUE_W-1:0]  value,
  input  logic signed [sis_pkg::VALUE_W-1:0]  upper,    // entry of the next cell
  input  logic                                seen_in,  // match in a lower cell
  output logic signed [sis_pkg::VALUE_W-1:0]  entry,
  output logic                                seen_out
);
  import sis_pkg::*;

  logic match;

  // Compare the held entry and extend the match chain
  assign match    = live && (entry == value);
  assign seen_out = seen_in | match;

  // Append at the tail when no lower match; shift down from the match on remove
  always_ff @(posedge clk) begin
    if (ctl.ins && tail && !seen_in) begin
      entry <= value;
    end else if (ctl.rem && seen_out) begin
      entry <= upper;
    end
  end

endmodule

@@ design/small_integer_set_store.sv @@
`timescale 1ns / 1ps
// Set store of up to CAPACITY distinct signed 32-bit integers in insertion order,
// held in a row of cells that compare against the request value in parallel and
// shift one place down on a remove. A request is accepted, served by the cell row
// in that cycle, and its result appears in the output register on the next
// cycle; a new request is taken every cycle as long as the output register is
// empty or is drained in the same cycle. The rate is set by the compare and
// match chain, which runs combinationally across the cell row. No clearing pass
// follows reset: the store is empty once the count is zero. The request kind
// travels in s_tuser; element_count reports the low 5 bits of the count.
`include "small_integer_set_store_macros.svh"
module small_integer_set_store #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], index[35:32], zero fill
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // found[0], read_value[32:1], element_count[37:33],
                                 // status[40:38], zero fill
);
  import sis_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic                      in_fire;
  logic                      out_fire;
  logic [1:0]                req_type;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]        index;
  cell_ctl_t                 ctl;

  logic signed [VALUE_W-1:0] entries [CAPACITY];
  logic signed [VALUE_W-1:0] uppers  [CAPACITY];
  logic [CAPACITY:0]         seen;

  logic                      any_match;
  logic                      full;
  logic                      found_next;
  logic signed [VALUE_W-1:0] read_next;
  logic [2:0]                status_next;
  logic signed [VALUE_W-1:0] rd_sel;

  logic                      out_valid;
  logic                      out_found;
  logic signed [VALUE_W-1:0] out_read;
  logic [4:0]                out_count;
  logic [2:0]                out_status;

  // Unpack the request
  assign req_type = s_tuser;
  assign value    = s_tdata[VALUE_W-1:0];
  assign index    = s_tdata[VALUE_W+INDEX_W-1:VALUE_W];

  assign s_tready = !out_valid || m_tready;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = out_valid && m_tready;

  assign ctl.ins = in_fire && (req_type == REQ_INSERT);
  assign ctl.rem = in_fire && (req_type == REQ_REMOVE);

  // Row of cells with the match chain running upward
  assign seen[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_last
      assign uppers[i] = entries[i];
    end else begin : g_mid
      assign uppers[i] = entries[i+1];
    end
    sis_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .live     (CNT_W'(i) < count),
      .tail     (CNT_W'(i) == count),
      .value    (value),
      .upper    (uppers[i]),
      .seen_in  (seen[i]),
      .entry    (entries[i]),
      .seen_out (seen[i+1])
    );
  end

  assign any_match = seen[CAPACITY];
  assign full      = (count == CNT_W'(CAPACITY));

  // Select the entry for a read by index
  always_comb begin
    rd_sel = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (k < (1 << INDEX_W) && INDEX_W'(k) == index) begin
        rd_sel = rd_sel | entries[k];
      end
    end
  end

  // Build the result and the next count
  always_comb begin
    found_next  = 1'b0;
    read_next   = '0;
    status_next = ST_OK;
    count_next  = count;
    case (req_type)
      REQ_INSERT: begin
        if (any_match) begin
          found_next  = 1'b1;
          status_next = ST_PRESENT;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (any_match) begin
          found_next = 1'b1;
          count_next = count - CNT_W'(1);
        end else begin
          status_next = ST_ABSENT;
        end
      end
      REQ_CONTAINS: begin
        if (any_match) begin
          found_next = 1'b1;
        end else begin
          status_next = ST_ABSENT;
        end
      end
      default: begin
        if (CMP_W'(index) < CMP_W'(count)) begin
          read_next = rd_sel;
        end else begin
          status_next = ST_BADIDX;
        end
      end
    endcase
  end

  // Hold the count and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
    if (in_fire) begin
      out_found  <= found_next;
      out_read   <= read_next;
      out_count  <= 5'(count_next);
      out_status <= status_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_status, out_count, out_read, out_found};

  `SIS_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(CAPACITY), "count past capacity")
  `SIS_ASSERT_NXT(a_insert_grows, clk, rst, ctl.ins && !any_match && !full, count == $past(count) + CNT_W'(1), "insert did not grow count")
  `SIS_ASSERT_NXT(a_remove_shrinks, clk, rst, ctl.rem && any_match, count == $past(count) - CNT_W'(1), "remove did not shrink count")
  `SIS_ASSERT_IMP(a_bad_read_zero, clk, rst, out_valid && out_status == ST_BADIDX, out_read == '0 && !out_found, "bad index read carries data")

endmodule
